>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the orbit fragment deframer.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)

`endif

>>> hw/rtl/ofd_pkg.sv
// Package for the orbit fragment deframer: payload structs, codes and constants.
// Used by ofd_rem, ofd_ctrl, ofd_datapath and orbit_fragment_deframer.
`timescale 1ns / 1ps

package ofd_pkg;

  localparam int LANE_W       = 64;
  localparam int ORB_W        = 32;
  localparam int LEN_W        = 21;
  localparam int CFG16_W      = 16;
  localparam int CFG_DATA_W   = 21;
  localparam int CFG_IDX_W    = 2;
  localparam int COUNT_W      = 8;
  localparam int ERR_W        = 3;
  localparam int DIV_STEPS    = ORB_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam int MAX_ORBIT_WORDS = 1048576;

  localparam logic [7:0] MAGIC0    = 8'h47;
  localparam logic [7:0] MAGIC1    = 8'h5a;
  localparam logic [7:0] FULL_CNT  = 8'hff;
  localparam int         START_BIT = 47;
  localparam int         END_BIT   = 46;
  localparam int         CNT_LSB   = 48;
  localparam int         ORB_LSB   = 24;

  localparam logic [CFG16_W-1:0]    PRESCALE_RST  = 16'd1;
  localparam logic [CFG16_W-1:0]    OPF_RST       = 16'd1;
  localparam logic [CFG16_W-1:0]    PHASE_RST     = 16'd1;
  localparam logic [CFG_DATA_W-1:0] CAPACITY_RST  = 21'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE        = 2'd0,
    CFG_ORBITS_PER_FILE = 2'd1,
    CFG_FILE_PHASE      = 2'd2,
    CFG_CAPACITY        = 2'd3
  } cfg_idx_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_COUNT    = 3'd2,
    ERR_START    = 3'd3,
    ERR_CAPACITY = 3'd4
  } err_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane0;
    logic [LANE_W-1:0] lane1;
    logic [LANE_W-1:0] lane2;
    logic [LANE_W-1:0] lane3;
  } ofd_in_t;

  typedef struct packed {
    logic              payload_valid;
    logic [LANE_W-1:0] out_lane0;
    logic [LANE_W-1:0] out_lane1;
    logic [LANE_W-1:0] out_lane2;
    logic [LANE_W-1:0] out_lane3;
    logic              orbit_done;
    logic [ORB_W-1:0]  orbit_number;
    logic [LEN_W-1:0]  orbit_length;
    logic              truncated;
    logic              keep_orbit;
    logic              start_new_file;
    logic [ERR_W-1:0]  error_code;
  } ofd_out_t;

  typedef struct packed {
    logic take;
    logic start_div;
    logic step;
    logic push_div;
  } ofd_cmd_t;

  typedef struct packed {
    logic skid_full;
    logic finish_req;
  } ofd_sts_t;

endpackage

>>> hw/rtl/ofd_rem.sv
// Restoring remainder unit: one quotient bit per step, 32-bit dividend by 16-bit divisor.
// Depends on ofd_pkg for widths.
`timescale 1ns / 1ps

module ofd_rem (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [ofd_pkg::ORB_W-1:0]    dividend,
  input  logic [ofd_pkg::CFG16_W-1:0]  divisor,
  output logic [ofd_pkg::CFG16_W-1:0]  rem
);
  import ofd_pkg::*;

  logic [ORB_W-1:0]   dvd_r;
  logic [ORB_W-1:0]   dvd_nxt;
  logic [CFG16_W-1:0] div_r;
  logic [CFG16_W-1:0] rem_r;
  logic [CFG16_W-1:0] rem_nxt;
  logic [CFG16_W:0]   shifted;

  always_comb begin
    shifted = {rem_r, dvd_r[ORB_W-1]};
    dvd_nxt = {dvd_r[ORB_W-2:0], 1'b0};
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = CFG16_W'(shifted - {1'b0, div_r});
    end else begin
      rem_nxt = shifted[CFG16_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule

>>> hw/rtl/ofd_ctrl.sv
// Controller state machine: accepts words and sequences the remainder steps of an orbit summary.
// Depends on ofd_pkg for the command and status structs.
`timescale 1ns / 1ps

module ofd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ofd_pkg::ofd_sts_t sts,
  output ofd_pkg::ofd_cmd_t cmd
);
  import ofd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take      = in_valid && !sts.skid_full;
        cmd.start_div = cmd.take && sts.finish_req;
        if (cmd.start_div) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push_div = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE) || sts.skid_full;

endmodule

>>> hw/rtl/ofd_datapath.sv
// Datapath: configuration registers, deframing state, orbit summary and two-entry output queue.
// Depends on ofd_pkg, ofd_rem and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ofd_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ofd_pkg::ofd_cmd_t               cmd,
  output ofd_pkg::ofd_sts_t               sts,
  input  ofd_pkg::ofd_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ofd_pkg::ofd_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [ofd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ofd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ofd_pkg::*;

  logic [CFG16_W-1:0]    prescale_r;
  logic [CFG16_W-1:0]    opf_r;
  logic [CFG16_W-1:0]    phase_r;
  logic [CFG_DATA_W-1:0] capacity_r;

  logic               expect_header_r, expect_header_nxt;
  logic               expect_first_r, expect_first_nxt;
  logic [COUNT_W-1:0] words_left_r, words_left_nxt;
  logic               fragment_final_r, fragment_final_nxt;
  logic [LEN_W-1:0]   length_count_r, length_count_nxt;
  logic [ORB_W-1:0]   current_orbit_r, current_orbit_nxt;
  logic               file_open_r;

  ofd_out_t         snap_r;
  logic [ORB_W-1:0] snap_orb_r;
  logic [LEN_W-1:0] snap_len_r;
  logic             snap_fopen_r;

  ofd_out_t out_r, skid_r;
  logic     out_valid_r, skid_valid_r;

  ofd_out_t           item_res, fin_res, res;
  logic               finish_req;
  logic [ORB_W-1:0]   fin_orb;
  logic [LEN_W-1:0]   fin_len;
  logic [LANE_W-1:0]  hdr;
  logic               magic_ok, hdr_start, hdr_end;
  logic [COUNT_W-1:0] count;
  logic [LEN_W-1:0]   len_base, len_new, cap;
  logic [ORB_W-1:0]   orb_base, orb_new;
  logic [COUNT_W-1:0] wl_new;
  err_t               code;
  logic [CFG16_W-1:0] rem_p, rem_o;
  logic [ORB_W-1:0]   residue;
  logic               push, pop, head_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RST;
      opf_r      <= OPF_RST;
      phase_r    <= PHASE_RST;
      capacity_r <= CAPACITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESCALE:        prescale_r <= cfg_wdata[CFG16_W-1:0];
        CFG_ORBITS_PER_FILE: opf_r      <= cfg_wdata[CFG16_W-1:0];
        CFG_FILE_PHASE:      phase_r    <= cfg_wdata[CFG16_W-1:0];
        CFG_CAPACITY:        capacity_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    hdr       = in_data.lane0;
    magic_ok  = (hdr[7:0] == MAGIC0) && (hdr[15:8] == MAGIC1);
    hdr_start = hdr[START_BIT];
    hdr_end   = hdr[END_BIT];
    count     = hdr[CNT_LSB +: COUNT_W];
    cap       = (capacity_r > LEN_W'(MAX_ORBIT_WORDS)) ? LEN_W'(MAX_ORBIT_WORDS) : capacity_r;
    len_base  = expect_first_r ? '0 : length_count_r;
    orb_base  = expect_first_r ? '0 : current_orbit_r;
    orb_new   = (length_count_r == '0) ? in_data.lane0[ORB_LSB +: ORB_W] : current_orbit_r;
    len_new   = length_count_r + 1'b1;
    wl_new    = (words_left_r != '0) ? words_left_r - 1'b1 : words_left_r;

    if (!magic_ok) begin
      code = ERR_MAGIC;
    end else if (!hdr_end && (count != FULL_CNT)) begin
      code = ERR_COUNT;
    end else if (expect_first_r && !hdr_start) begin
      code = ERR_START;
    end else if (({1'b0, len_base} + (LEN_W + 1)'(count)) >= {1'b0, cap}) begin
      code = ERR_CAPACITY;
    end else begin
      code = ERR_NONE;
    end

    item_res           = '0;
    finish_req         = 1'b0;
    fin_orb            = orb_base;
    fin_len            = len_base;
    expect_header_nxt  = expect_header_r;
    expect_first_nxt   = expect_first_r;
    words_left_nxt     = words_left_r;
    fragment_final_nxt = fragment_final_r;
    length_count_nxt   = length_count_r;
    current_orbit_nxt  = current_orbit_r;

    if (expect_header_r) begin
      if (code != ERR_NONE) begin
        item_res.error_code = code;
        expect_first_nxt    = 1'b1;
        words_left_nxt      = '0;
        fragment_final_nxt  = 1'b0;
        length_count_nxt    = '0;
        current_orbit_nxt   = '0;
      end else begin
        expect_first_nxt   = 1'b0;
        fragment_final_nxt = hdr_end;
        words_left_nxt     = count;
        length_count_nxt   = len_base;
        current_orbit_nxt  = orb_base;
        if (count == '0) begin
          finish_req = 1'b1;
        end else begin
          expect_header_nxt = 1'b0;
        end
      end
    end else begin
      item_res.payload_valid = 1'b1;
      item_res.out_lane0     = in_data.lane0;
      item_res.out_lane1     = in_data.lane1;
      item_res.out_lane2     = in_data.lane2;
      item_res.out_lane3     = in_data.lane3;
      current_orbit_nxt      = orb_new;
      length_count_nxt       = len_new;
      words_left_nxt         = wl_new;
      fin_orb                = orb_new;
      fin_len                = len_new;
      if (wl_new == '0) begin
        if (fragment_final_r) begin
          finish_req = 1'b1;
        end else begin
          expect_header_nxt = 1'b1;
        end
      end
    end

    if (finish_req) begin
      expect_header_nxt  = 1'b1;
      expect_first_nxt   = 1'b1;
      words_left_nxt     = '0;
      fragment_final_nxt = 1'b0;
      length_count_nxt   = '0;
      current_orbit_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r  <= 1'b1;
      expect_first_r   <= 1'b1;
      words_left_r     <= '0;
      fragment_final_r <= 1'b0;
      length_count_r   <= '0;
      current_orbit_r  <= '0;
      file_open_r      <= 1'b0;
    end else if (cmd.take) begin
      expect_header_r  <= expect_header_nxt;
      expect_first_r   <= expect_first_nxt;
      words_left_r     <= words_left_nxt;
      fragment_final_r <= fragment_final_nxt;
      length_count_r   <= length_count_nxt;
      current_orbit_r  <= current_orbit_nxt;
      if (finish_req) begin
        file_open_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      snap_r       <= item_res;
      snap_orb_r   <= fin_orb;
      snap_len_r   <= fin_len;
      snap_fopen_r <= file_open_r;
    end
  end

  ofd_rem u_rem_prescale (
    .clk      (clk),
    .load     (cmd.start_div),
    .step     (cmd.step),
    .dividend (fin_orb),
    .divisor  (prescale_r),
    .rem      (rem_p)
  );

  ofd_rem u_rem_file (
    .clk      (clk),
    .load     (cmd.start_div),
    .step     (cmd.step),
    .dividend (fin_orb),
    .divisor  (opf_r),
    .rem      (rem_o)
  );

  always_comb begin
    residue                = (opf_r == '0) ? snap_orb_r : ORB_W'(rem_o);
    fin_res                = snap_r;
    fin_res.orbit_done     = 1'b1;
    fin_res.orbit_number   = snap_orb_r;
    fin_res.orbit_length   = snap_len_r;
    fin_res.truncated      = (snap_len_r <= LEN_W'(1));
    fin_res.keep_orbit     = (prescale_r != '0) &&
                             ((prescale_r == CFG16_W'(1)) || (rem_p == CFG16_W'(1)));
    fin_res.start_new_file = !snap_fopen_r || (residue == ORB_W'(phase_r));
    fin_res.error_code     = ERR_NONE;
  end

  assign push      = (cmd.take && !finish_req) || cmd.push_div;
  assign res       = cmd.push_div ? fin_res : item_res;
  assign pop       = out_valid_r && !out_stall;
  assign head_free = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
      if (push) begin
        if (head_free && !(pop && skid_valid_r)) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_r <= skid_r;
    end else if (push && head_free) begin
      out_r <= res;
    end
    if (push && !(head_free && !(pop && skid_valid_r))) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign sts.skid_full  = skid_valid_r;
  assign sts.finish_req = finish_req;

  `ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && skid_valid_r, "push into a full output queue")
  `ASSERT_NEVER(a_skid_behind_head, clk, rst_n, skid_valid_r && !out_valid_r, "skid entry without head entry")
  `ASSERT_NEVER(a_done_without_error, clk, rst_n, push && res.orbit_done && (res.error_code != ERR_NONE), "orbit summary carries an error code")
  `ASSERT_PROP(a_finish_rearms, clk, rst_n, (cmd.take && finish_req) |=> (expect_header_r && expect_first_r), "completed orbit did not rearm the first header")

endmodule

>>> hw/rtl/orbit_fragment_deframer.sv
// Usage: the input channel (in_valid, in_stall, in_data) carries 256-bit words as four lanes.
// Header words are stripped; each accepted word yields exactly one transaction on the output
// channel (out_valid, out_stall, out_data) with payload, orbit summary or error code.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the block is idle.
// A word that does not complete an orbit gives its result through the registered output queue.
// A word that completes an orbit gives its result from ST_PUSH, after ST_DIV, in which the two
// remainder units (orbit mod prescale, orbit mod orbits_per_file) take one bit per cycle over
// the 32-bit orbit number, and in_stall stays high meanwhile.
// Within an orbit one word is accepted per cycle while the output queue has room.
// A two-entry output queue lets a new word be accepted while a result waits for the receiver;
// when both entries are full in_stall is raised until the receiver takes a transaction.
// Reset (rst_n low at a clock edge) empties the queue, restores the register defaults and
// arms the block for a first header. No memory needs clearing after reset.
// Depends on ofd_pkg, ofd_ctrl and ofd_datapath.
`timescale 1ns / 1ps

module orbit_fragment_deframer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ofd_pkg::ofd_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ofd_pkg::ofd_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [ofd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ofd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ofd_pkg::*;

  ofd_cmd_t cmd;
  ofd_sts_t sts;

  ofd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ofd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
